/* rtl/core/kfi_pkg.sv */
package kfi_pkg;

   // Field widths of the channels and registers.
   localparam int FRAME_BITS    = 16;
   localparam int FRACTION_BITS = 16;
   localparam int TIME_BITS     = 32;
   localparam int RATE_BITS     = 16;
   localparam int MODE_BITS     = 2;

   // Frame position is time times rate, with 24 fractional bits.
   localparam int POS_BITS      = TIME_BITS + RATE_BITS;
   localparam int POS_FRAC_BITS = 24;
   localparam int WHOLE_BITS    = POS_BITS - POS_FRAC_BITS;

   // The modulo unit retires DIGIT_BITS quotient bits per pipeline stage.
   localparam int DIGIT_BITS    = 4;
   localparam int MOD_STAGES    = WHOLE_BITS / DIGIT_BITS;
   localparam int DIV_BITS      = FRAME_BITS + 1;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = (FRAME_BITS > RATE_BITS) ? FRAME_BITS : RATE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLAY_MODE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_RATE     = 2'd2;

   // Play modes.
   localparam logic [MODE_BITS-1:0] MODE_LOOP   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SINGLE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MIRROR = 2'd2;

   // Reset value of the frame rate: 30 frames per second in Q8.8.
   localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd7680;

endpackage

/* rtl/core/kfi_if.sv */
// Request channel: one playback time per beat.
interface kfi_req_if;
   logic                            valid;
   logic                            ready;
   logic [kfi_pkg::TIME_BITS-1:0]   play_time;

   modport source (output valid, output play_time, input ready);
   modport sink   (input valid, input play_time, output ready);
endinterface

// Response channel: one keyframe pair and blend weight per beat.
interface kfi_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [kfi_pkg::FRAME_BITS-1:0]    first_frame;
   logic [kfi_pkg::FRAME_BITS-1:0]    second_frame;
   logic [kfi_pkg::FRACTION_BITS:0]   fraction;

   modport source (output valid, output first_frame, output second_frame,
                   output fraction, input ready);
   modport sink   (input valid, input first_frame, input second_frame,
                   input fraction, output ready);
endinterface

/* rtl/core/keyframe_interpolation_index.sv */
// Keyframe interpolation index.
// A request beat carries a playback time (unsigned Q16.16 seconds). The block
// multiplies it by the frame rate and returns, on the response channel, the
// pair of keyframes to blend and the weight of the later one (Q0.16, where
// 65536 is exactly 1.0). Loop, single-play and mirror modes are selected by
// the play_mode register; interval_count and frame_rate are set through the
// csr write port, which should only be used while no beat is in flight.
// Request acceptance leads to response valid through one stage for the 32x16
// multiplier, six stages of the modulo unit (4 position bits each, 24 bits of
// integer frame position) and one stage for the mirror fold, the end clamp and
// the output register. Without a stall, a new beat is accepted every cycle.
// Each stage carries its own valid bit and holds only when the stage after it
// is full, so a stalled receiver backs the pipeline up one stage at a time and
// req ready falls only once all eight stages hold a beat.
// Synchronous reset empties the pipeline and sets loop mode, zero frames and
// a rate of 30 frames per second.
module keyframe_interpolation_index (
   input  logic                                clock,
   input  logic                                reset,
   kfi_req_if.sink                             req_bus,
   kfi_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [kfi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [kfi_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import kfi_pkg::*;

   localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   // Configuration registers.
   logic [MODE_BITS-1:0]  play_mode_ff;
   logic [FRAME_BITS-1:0] interval_count_ff;
   logic [RATE_BITS-1:0]  frame_rate_ff;

   // Pipeline stages: index 0 holds the product, 1..MOD_STAGES the remainder.
   logic                     stg_valid_ff [0:MOD_STAGES];
   logic [DIV_BITS-1:0]      stg_rem_ff   [0:MOD_STAGES];
   logic [WHOLE_BITS-1:0]    stg_whole_ff [0:MOD_STAGES];
   logic [FRACTION_BITS-1:0] stg_frac_ff  [0:MOD_STAGES];
   logic [DIV_BITS-1:0]      stg_rem_in   [0:MOD_STAGES];
   logic                     stg_load     [0:MOD_STAGES];

   // Output register.
   logic                     out_valid_ff;
   logic [FRAME_BITS-1:0]    out_first_ff;
   logic [FRAME_BITS-1:0]    out_second_ff;
   logic [FRACTION_BITS:0]   out_frac_ff;
   logic [FRAME_BITS-1:0]    out_first_in;
   logic [FRAME_BITS-1:0]    out_second_in;
   logic [FRACTION_BITS:0]   out_frac_in;
   logic                     out_load;

   logic [POS_BITS-1:0]      position;
   logic [DIV_BITS-1:0]      divisor;

   // Configuration writes; unknown indices are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         play_mode_ff      <= MODE_LOOP;
         interval_count_ff <= '0;
         frame_rate_ff     <= RATE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PLAY_MODE: begin
               play_mode_ff <= csr_write_data[MODE_BITS-1:0];
            end
            CSR_INTERVAL_COUNT: begin
               interval_count_ff <= csr_write_data[FRAME_BITS-1:0];
            end
            CSR_FRAME_RATE: begin
               frame_rate_ff <= csr_write_data[RATE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A stage may load when it is empty or the stage after it is loading.
   always_comb begin
      out_load = !out_valid_ff || rsp_bus.ready;
      stg_load[MOD_STAGES] = !stg_valid_ff[MOD_STAGES] || out_load;
      for (int k = MOD_STAGES - 1; k >= 0; k--) begin
         stg_load[k] = !stg_valid_ff[k] || stg_load[k+1];
      end
   end

   assign req_bus.ready = stg_load[0];

   // Frame position and the modulus (twice the frame count when mirroring).
   assign position = POS_BITS'(req_bus.play_time) * POS_BITS'(frame_rate_ff);
   assign divisor  = (play_mode_ff == MODE_MIRROR) ? {interval_count_ff, 1'b0}
                                                   : {1'b0, interval_count_ff};

   // Restoring remainder: each stage shifts in DIGIT_BITS bits of the position.
   always_comb begin
      logic [DIV_BITS:0] part;
      logic [DIV_BITS-1:0] rem;
      stg_rem_in[0] = '0;
      for (int k = 1; k <= MOD_STAGES; k++) begin
         rem = stg_rem_ff[k-1];
         for (int j = 0; j < DIGIT_BITS; j++) begin
            part = {rem, stg_whole_ff[k-1][WHOLE_BITS - 1 - (k - 1) * DIGIT_BITS - j]};
            if (part >= {1'b0, divisor}) begin
               part = part - {1'b0, divisor};
            end
            rem = part[DIV_BITS-1:0];
         end
         stg_rem_in[k] = rem;
      end
   end

   // Pipeline registers: valid bits are reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= MOD_STAGES; k++) begin
            stg_valid_ff[k] <= 1'b0;
         end
      end else begin
         if (stg_load[0]) begin
            stg_valid_ff[0] <= req_bus.valid;
         end
         for (int k = 1; k <= MOD_STAGES; k++) begin
            if (stg_load[k]) begin
               stg_valid_ff[k] <= stg_valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_load[0]) begin
         stg_rem_ff[0]   <= stg_rem_in[0];
         stg_whole_ff[0] <= position[POS_BITS-1:POS_FRAC_BITS];
         stg_frac_ff[0]  <= position[POS_FRAC_BITS-1 -: FRACTION_BITS];
      end
      for (int k = 1; k <= MOD_STAGES; k++) begin
         if (stg_load[k]) begin
            stg_rem_ff[k]   <= stg_rem_in[k];
            stg_whole_ff[k] <= stg_whole_ff[k-1];
            stg_frac_ff[k]  <= stg_frac_ff[k-1];
         end
      end
   end

   // Final stage: pick the pair per mode, fold for mirror, clamp for single.
   always_comb begin
      logic [DIV_BITS-1:0] rem;
      logic [DIV_BITS-1:0] rem_next;
      logic [DIV_BITS-1:0] fold_a;
      logic [DIV_BITS-1:0] fold_b;
      logic [DIV_BITS-1:0] span;
      rem      = stg_rem_ff[MOD_STAGES];
      rem_next = rem + 1'b1;
      span     = {interval_count_ff, 1'b0};
      fold_a   = (rem <= {1'b0, interval_count_ff}) ? rem : span - rem;
      fold_b   = (rem_next <= {1'b0, interval_count_ff}) ? rem_next : span - rem_next;
      out_first_in  = '0;
      out_second_in = '0;
      out_frac_in   = '0;
      if (interval_count_ff != '0) begin
         case (play_mode_ff)
            MODE_LOOP: begin
               out_first_in  = rem[FRAME_BITS-1:0];
               out_second_in = rem[FRAME_BITS-1:0] + 1'b1;
               out_frac_in   = {1'b0, stg_frac_ff[MOD_STAGES]};
            end
            MODE_SINGLE: begin
               if (stg_whole_ff[MOD_STAGES] >= WHOLE_BITS'(interval_count_ff)) begin
                  out_first_in  = interval_count_ff - 1'b1;
                  out_second_in = interval_count_ff;
                  out_frac_in   = FRAC_ONE;
               end else begin
                  out_first_in  = stg_whole_ff[MOD_STAGES][FRAME_BITS-1:0];
                  out_second_in = stg_whole_ff[MOD_STAGES][FRAME_BITS-1:0] + 1'b1;
                  out_frac_in   = {1'b0, stg_frac_ff[MOD_STAGES]};
               end
            end
            MODE_MIRROR: begin
               out_first_in  = fold_a[FRAME_BITS-1:0];
               out_second_in = fold_b[FRAME_BITS-1:0];
               out_frac_in   = {1'b0, stg_frac_ff[MOD_STAGES]};
            end
            default: begin
            end
         endcase
      end
   end

   // Output register: holds its beat until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= stg_valid_ff[MOD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_frac_ff   <= out_frac_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.first_frame  = out_first_ff;
   assign rsp_bus.second_frame = out_second_ff;
   assign rsp_bus.fraction     = out_frac_ff;

   // An empty output register never holds off the request side.
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_bus.ready)
      else $error("request ready low while output register is empty");

   // Every accepted beat lands in the first stage.
   a_accept_fills_stage0: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> stg_valid_ff[0])
      else $error("accepted beat did not enter the pipeline");

   // The weight never exceeds one.
   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.fraction <= FRAC_ONE)
      else $error("fraction above 1.0");

   // A full weight only comes from the end clamp, which gives adjacent frames.
   a_clamp_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.fraction[FRACTION_BITS] |->
         rsp_bus.second_frame == FRAME_BITS'(rsp_bus.first_frame + 1'b1))
      else $error("clamped result is not an adjacent frame pair");

endmodule

/* tb/keyframe_interpolation_index_tb.sv */
module keyframe_interpolation_index_tb;
   import kfi_pkg::*;

   // The fourth play mode value has no meaning and must give an all-zero beat.
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BEATS = 110;
   localparam int JUNK_BITS = CSR_DATA_BITS - MODE_BITS;

   typedef struct packed {
      logic [FRAME_BITS-1:0]    first_frame;
      logic [FRAME_BITS-1:0]    second_frame;
      logic [FRACTION_BITS:0]   fraction;
   } keyframe_pair_type;

   // Keeps its own copy of the registers, works out the keyframe pair for every
   // accepted time and compares response beats with them in order.
   class keyframe_scoreboard;
      logic [MODE_BITS-1:0]   mode;
      logic [FRAME_BITS-1:0]  interval_count;
      logic [RATE_BITS-1:0]   frame_rate;
      keyframe_pair_type      awaited[$];
      int                     failures;

      function new();
         mode = MODE_LOOP;
         interval_count = '0;
         frame_rate = RATE_RESET;
         failures = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_PLAY_MODE: begin
               mode = data[MODE_BITS-1:0];
            end
            CSR_INTERVAL_COUNT: begin
               interval_count = data[FRAME_BITS-1:0];
            end
            CSR_FRAME_RATE: begin
               frame_rate = data[RATE_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Folds a position in the doubled span back onto the forward track.
      function logic [FRAME_BITS-1:0] fold_back(logic [FRAME_BITS:0] f);
         logic [FRAME_BITS:0] span;
         span = {interval_count, 1'b0};
         if (f <= {1'b0, interval_count})
            return f[FRAME_BITS-1:0];
         return FRAME_BITS'(span - f);
      endfunction

      function keyframe_pair_type lookup_frames(logic [TIME_BITS-1:0] play_time);
         logic [POS_BITS-1:0]      position;
         logic [WHOLE_BITS-1:0]    whole;
         logic [FRACTION_BITS-1:0] part;
         logic [FRAME_BITS:0]      span;
         logic [FRAME_BITS:0]      wrapped;
         keyframe_pair_type        pair;
         position = POS_BITS'(play_time) * POS_BITS'(frame_rate);
         whole = position[POS_BITS-1:POS_FRAC_BITS];
         // The low position bits are simply dropped.
         part = position[POS_FRAC_BITS-1:POS_FRAC_BITS-FRACTION_BITS];
         pair = '0;
         if (interval_count == '0)
            return pair;
         case (mode)
            MODE_LOOP: begin
               wrapped = (FRAME_BITS + 1)'(whole % interval_count);
               pair.first_frame = wrapped[FRAME_BITS-1:0];
               pair.second_frame = FRAME_BITS'(wrapped + 1'b1);
               pair.fraction = {1'b0, part};
            end
            MODE_SINGLE: begin
               // At or past the end the last pair is held at full weight.
               if (whole >= WHOLE_BITS'(interval_count)) begin
                  pair.first_frame = interval_count - 1'b1;
                  pair.second_frame = interval_count;
                  pair.fraction = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
               end else begin
                  pair.first_frame = whole[FRAME_BITS-1:0];
                  pair.second_frame = whole[FRAME_BITS-1:0] + 1'b1;
                  pair.fraction = {1'b0, part};
               end
            end
            MODE_MIRROR: begin
               span = {interval_count, 1'b0};
               wrapped = (FRAME_BITS + 1)'(whole % span);
               pair.first_frame = fold_back(wrapped);
               pair.second_frame = fold_back(wrapped + 1'b1);
               pair.fraction = {1'b0, part};
            end
            default: begin
            end
         endcase
         return pair;
      endfunction

      function void note_request(logic [TIME_BITS-1:0] play_time);
         awaited.push_back(lookup_frames(play_time));
      endfunction

      task report(string what);
         failures++;
         if (failures <= 100)
            $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_response(keyframe_pair_type got);
         keyframe_pair_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected beat %0d/%0d/%0d", got.first_frame,
                             got.second_frame, got.fraction));
            return;
         end
         want = awaited.pop_front();
         if (got.first_frame !== want.first_frame)
            report($sformatf("first_frame %0d, wanted %0d", got.first_frame,
                             want.first_frame));
         if (got.second_frame !== want.second_frame)
            report($sformatf("second_frame %0d, wanted %0d", got.second_frame,
                             want.second_frame));
         if (got.fraction !== want.fraction)
            report($sformatf("fraction %0d, wanted %0d", got.fraction,
                             want.fraction));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_write_data;
   int                         cycle_count = 0;
   bit                         req_no_idle = 1'b0;
   bit                         rsp_no_stall = 1'b0;
   keyframe_scoreboard         sb = new();

   kfi_req_if req_bus ();
   kfi_rsp_if rsp_bus ();

   keyframe_interpolation_index uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Free-running clock with a period of ten.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Drives one register; the enable is left high for the caller to lower.
   task automatic put_register(logic [CSR_INDEX_BITS-1:0] index,
                               logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      sb.write_register(index, data);
   endtask

   // Writes all three registers; unused upper bits of the mode word carry junk.
   task automatic configure(logic [MODE_BITS-1:0] mode_sel, logic [FRAME_BITS-1:0] count,
                            logic [RATE_BITS-1:0] rate, logic [JUNK_BITS-1:0] junk);
      put_register(CSR_PLAY_MODE, {junk, mode_sel});
      put_register(CSR_INTERVAL_COUNT, count);
      put_register(CSR_FRAME_RATE, rate);
      csr_write_enable <= 1'b0;
   endtask

   // Offers one time after a random gap and returns on the edge that takes it.
   task automatic send_time(logic [TIME_BITS-1:0] play_time);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.play_time <= play_time;
      @(negedge clock);
      while (!req_bus.ready)
         @(negedge clock);
      @(posedge clock);
      sb.note_request(play_time);
   endtask

   // Lowers valid and waits until every outstanding beat has come back.
   task automatic finish_phase();
      req_bus.valid <= 1'b0;
      while (sb.awaited.size() != 0)
         @(posedge clock);
   endtask

   // Receiver: random back-pressure, one beat taken per handshake.
   task automatic take_responses();
      int gap;
      keyframe_pair_type got;
      forever begin
         gap = rsp_no_stall ? 0 : $urandom_range(0, 4);
         repeat (gap) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_bus.valid)
            @(negedge clock);
         got.first_frame = rsp_bus.first_frame;
         got.second_frame = rsp_bus.second_frame;
         got.fraction = rsp_bus.fraction;
         @(posedge clock);
         sb.check_response(got);
      end
   endtask

   function automatic logic [TIME_BITS-1:0] pick_time();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return $urandom_range(0, 1) ? '1 : '0;
      if (r <= 2)
         return $urandom_range(0, 32'h0003ffff);
      return $urandom;
   endfunction

   // Draws a register setting for one phase, leaning on the edges of each range.
   task automatic random_setting();
      int r;
      logic [MODE_BITS-1:0]  mode_sel;
      logic [FRAME_BITS-1:0] count;
      logic [RATE_BITS-1:0]  rate;
      r = $urandom_range(0, 9);
      mode_sel = (r < 3) ? MODE_LOOP : (r < 6) ? MODE_SINGLE : (r < 9) ? MODE_MIRROR
                                                                      : MODE_UNUSED;
      case ($urandom_range(0, 7))
         0: count = '0;
         1: count = 16'd1;
         2: count = '1;
         3, 4: count = FRAME_BITS'($urandom_range(2, 16));
         5, 6: count = FRAME_BITS'($urandom_range(17, 4096));
         default: count = FRAME_BITS'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: rate = '0;
         1: rate = 16'd1;
         2: rate = '1;
         default: rate = RATE_BITS'($urandom);
      endcase
      configure(mode_sel, count, rate, JUNK_BITS'($urandom));
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_PLAY_MODE;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.play_time <= '0;
      rsp_bus.ready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      fork
         take_responses();
      join_none

      // Reset values: zero frames gives all zeros.
      send_time('0);
      send_time('1);
      finish_phase();

      // Looping over ten frames at thirty per second.
      configure(MODE_LOOP, 16'd10, RATE_RESET, '0);
      send_time('0);
      send_time(32'h0000_0001);
      send_time(32'h0001_0000);
      send_time(32'h0000_8888);
      send_time('1);
      finish_phase();

      // Single play: fraction truncation, just short of the end, and past it.
      configure(MODE_SINGLE, 16'd10, RATE_RESET, '0);
      send_time(32'h0000_5555);
      send_time(32'h0000_5000);
      send_time(32'h0000_5556);
      send_time('1);
      finish_phase();

      // Mirror: the turning point and the folded second half.
      configure(MODE_MIRROR, 16'd10, RATE_RESET, '0);
      send_time(32'h0000_5556);
      send_time(32'h0000_8000);
      send_time(32'h0000_c000);
      send_time('1);
      finish_phase();

      // The unused mode value.
      configure(MODE_UNUSED, 16'd10, RATE_RESET, '1);
      send_time(32'h1234_5678);
      finish_phase();

      // A zero rate pins the position at zero.
      configure(MODE_MIRROR, 16'd10, '0, '0);
      send_time('1);
      finish_phase();

      // Largest rate and frame count.
      configure(MODE_LOOP, '1, '1, '0);
      send_time('1);
      send_time('0);
      finish_phase();

      // Random settings and times, some phases without any idling.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         req_no_idle = ($urandom_range(0, 3) == 0);
         rsp_no_stall = ($urandom_range(0, 3) == 0);
         random_setting();
         for (int n = 0; n < PHASE_BEATS; n++)
            send_time(pick_time());
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/core/kfi_pkg.sv
rtl/core/kfi_if.sv
rtl/core/keyframe_interpolation_index.sv
tb/keyframe_interpolation_index_tb.sv
